[hdl/bsuh_pkg.sv]
// ----------------------------------------------------------------------------
// bsuh_pkg
// Shared constants, register indexes and beat types for the byte sample
// unpacker with per-digitizer histograms.
// ----------------------------------------------------------------------------
package bsuh_pkg;

   localparam int MaxChannels = 64;
   localparam int ChannelTop  = (MaxChannels < 64) ? MaxChannels : 64;
   localparam int HistBins    = 256;
   localparam int Digitizers  = 256;
   localparam int HistEntries = Digitizers * HistBins;
   localparam int AddrW       = $clog2(HistEntries);
   localparam int CountWidth  = 32;
   localparam int BinCountW   = 32;

   localparam int CmdDepth    = 4;
   localparam int RspDepth    = 4;
   localparam int RspCntW     = $clog2(RspDepth + 1);

   localparam int CsrIdxW     = 2;
   localparam int CsrDataW    = 8;

   localparam logic [CsrIdxW-1:0] CsrSignedMode   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrChannelCount = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrPolCount     = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrDimCount     = 2'd3;

   localparam logic [7:0] OffsetFlip = 8'h80;

   localparam logic ModeSample   = 1'b0;
   localparam logic ModeReadback = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] sample_byte;
      logic [7:0] read_digitizer;
      logic [7:0] read_bin;
   } bsuh_req_type;

   typedef struct packed {
      logic                  is_readback;
      logic signed [7:0]     sample_value;
      logic [5:0]            channel_index;
      logic                  pol_index;
      logic                  dim_index;
      logic [BinCountW-1:0]  bin_count;
   } bsuh_rsp_type;

   typedef struct packed {
      logic              is_readback;
      logic signed [7:0] sample_value;
      logic [5:0]        channel_index;
      logic              pol_index;
      logic              dim_index;
      logic [AddrW-1:0]  addr;
   } bsuh_cmd_type;

endpackage

[hdl/bsuh_fifo.sv]
// ----------------------------------------------------------------------------
// bsuh_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module bsuh_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  item_type                     push_data,
   output logic                         full,
   input  logic                         pop,
   output item_type                     head,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   item_type            store_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue empty after push");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count out of range");

endmodule

[hdl/bsuh_front.sv]
// ----------------------------------------------------------------------------
// bsuh_front
// Configuration registers, digitizer position and sample classification.
// ----------------------------------------------------------------------------
module bsuh_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsuh_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [bsuh_pkg::CsrDataW-1:0]  csr_data,
   input  logic                           req_push,
   output logic                           req_full,
   input  bsuh_pkg::bsuh_req_type         req_data,
   input  logic                           cmd_full,
   input  logic                           clearing,
   output logic                           cmd_push,
   output bsuh_pkg::bsuh_cmd_type         cmd_data
);
   import bsuh_pkg::*;

   logic        signed_mode_ff;
   logic [6:0]  channel_count_ff;
   logic [1:0]  pol_count_ff;
   logic [1:0]  dim_count_ff;
   logic [7:0]  pos_ff, pos_in;

   logic        cfg_we;
   logic        accept;
   logic        pol2, dim2;
   logic [1:0]  shift;
   logic [6:0]  nch;
   logic [8:0]  ndig;
   logic [7:0]  pos_cur;
   logic [8:0]  pos_inc;
   logic [7:0]  conv_value;

   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid && csr_ready;
   assign req_full  = cmd_full || clearing;
   assign accept    = req_push && !req_full;
   assign cmd_push  = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff   <= 1'b0;
         channel_count_ff <= 7'd1;
         pol_count_ff     <= 2'd2;
         dim_count_ff     <= 2'd2;
      end else if (cfg_we) begin
         case (csr_index)
            CsrSignedMode:   signed_mode_ff   <= csr_data[0];
            CsrChannelCount: channel_count_ff <= csr_data[6:0];
            CsrPolCount:     pol_count_ff     <= csr_data[1:0];
            CsrDimCount:     dim_count_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pol2 = pol_count_ff[1];
      dim2 = dim_count_ff[1];
      shift = {1'b0, pol2} + {1'b0, dim2};
      if (channel_count_ff == '0) begin
         nch = 7'd1;
      end else if (channel_count_ff > 7'(ChannelTop)) begin
         nch = 7'(ChannelTop);
      end else begin
         nch = channel_count_ff;
      end
      ndig    = {2'b00, nch} << shift;
      pos_cur = ({1'b0, pos_ff} >= ndig) ? '0 : pos_ff;
      pos_inc = {1'b0, pos_cur} + 9'd1;
      pos_in  = pos_ff;
      if (accept && req_data.mode == ModeSample) begin
         pos_in = (pos_inc >= ndig) ? '0 : pos_inc[7:0];
      end

      if (signed_mode_ff) begin
         conv_value = req_data.sample_byte;
      end else if (req_data.sample_byte == '0) begin
         conv_value = '0;
      end else begin
         conv_value = req_data.sample_byte ^ OffsetFlip;
      end

      if (req_data.mode == ModeReadback) begin
         cmd_data.is_readback   = 1'b1;
         cmd_data.sample_value  = '0;
         cmd_data.channel_index = '0;
         cmd_data.pol_index     = 1'b0;
         cmd_data.dim_index     = 1'b0;
         cmd_data.addr          = {req_data.read_digitizer, req_data.read_bin};
      end else begin
         cmd_data.is_readback   = 1'b0;
         cmd_data.sample_value  = conv_value;
         cmd_data.channel_index = 6'(pos_cur >> shift);
         cmd_data.pol_index     = pol2 & (dim2 ? pos_cur[1] : pos_cur[0]);
         cmd_data.dim_index     = dim2 & pos_cur[0];
         cmd_data.addr          = {pos_cur, req_data.sample_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == ModeSample && !csr_valid) |=> {1'b0, pos_ff} < ndig)
      else $error("digitizer position beyond digitizer count");

endmodule

[hdl/bsuh_back.sv]
// ----------------------------------------------------------------------------
// bsuh_back
// Histogram store: clearing pass, read-modify-write of bin counts with
// bypass of the last write, and result assembly.
// ----------------------------------------------------------------------------
module bsuh_back #(
   parameter int COUNT_WIDTH = bsuh_pkg::CountWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   input  bsuh_pkg::bsuh_cmd_type        cmd_head,
   output logic                          cmd_pop,
   input  logic [bsuh_pkg::RspCntW-1:0]  out_count,
   output logic                          out_push,
   output bsuh_pkg::bsuh_rsp_type        out_item,
   output logic                          clearing
);
   import bsuh_pkg::*;

   localparam int ExtW = (COUNT_WIDTH > BinCountW) ? COUNT_WIDTH : BinCountW;

   logic [COUNT_WIDTH-1:0] hist_mem [HistEntries];

   logic                   clear_ff, clear_in;
   logic [AddrW-1:0]       clear_addr_ff, clear_addr_in;
   logic                   s2_valid_ff;
   bsuh_cmd_type           s2_cmd_ff;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   wr_valid_ff, wr_valid_in;
   logic [AddrW-1:0]       wr_addr_ff;
   logic [COUNT_WIDTH-1:0] wr_data_ff;

   logic                   issue;
   logic [RspCntW:0]       credit_used;
   logic [COUNT_WIDTH-1:0] base_cnt, new_cnt;
   logic [ExtW-1:0]        cnt_ext;
   logic                   mem_we;
   logic [AddrW-1:0]       mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   assign clearing    = clear_ff;
   assign credit_used = {1'b0, out_count} + (RspCntW+1)'(s2_valid_ff);
   assign issue       = !cmd_empty && !clear_ff && (credit_used < (RspCntW+1)'(RspDepth));
   assign cmd_pop     = issue;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (&clear_addr_ff) begin
            clear_in = 1'b0;
         end
      end

      if (wr_valid_ff && wr_addr_ff == s2_cmd_ff.addr) begin
         base_cnt = wr_data_ff;
      end else begin
         base_cnt = rd_data_ff;
      end
      new_cnt = (&base_cnt) ? base_cnt : base_cnt + 1'b1;

      wr_valid_in = s2_valid_ff && !s2_cmd_ff.is_readback;
      mem_we      = clear_ff || wr_valid_in;
      mem_waddr   = clear_ff ? clear_addr_ff : s2_cmd_ff.addr;
      mem_wdata   = clear_ff ? '0 : new_cnt;

      cnt_ext = ExtW'(s2_cmd_ff.is_readback ? base_cnt : new_cnt);
      out_push               = s2_valid_ff;
      out_item.is_readback   = s2_cmd_ff.is_readback;
      out_item.sample_value  = s2_cmd_ff.sample_value;
      out_item.channel_index = s2_cmd_ff.channel_index;
      out_item.pol_index     = s2_cmd_ff.pol_index;
      out_item.dim_index     = s2_cmd_ff.dim_index;
      out_item.bin_count     = cnt_ext[BinCountW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s2_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s2_valid_ff   <= issue;
         wr_valid_ff   <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_cmd_ff <= cmd_head;
      end
      wr_addr_ff <= s2_cmd_ff.addr;
      wr_data_ff <= new_cnt;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= hist_mem[cmd_head.addr];
      end
   end

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> out_count < RspCntW'(RspDepth))
      else $error("result queue overrun");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clear_ff |=> !clear_ff)
      else $error("clearing pass restarted without reset");

   a_no_issue_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s2_valid_ff && !issue)
      else $error("histogram access during clearing pass");

endmodule

[hdl/byte_sample_unpack_histogram_core.sv]
// ----------------------------------------------------------------------------
// byte_sample_unpack_histogram_core
// Unpacks 8-bit digitizer bytes to signed samples and keeps one 256-bin
// histogram of raw byte values per digitizer.
//
// Request queue: req_push/req_full with req_data. A sample beat converts
// the byte, tags it with channel, polarisation and part, and bumps its
// bin; a readback beat returns one stored bin count.
// Response queue: rsp_empty/rsp_pop with rsp_data, one beat per request,
// in request order.
// Register port: csr_valid/csr_ready (always ready), csr_index, csr_data.
// Write only while no request is in flight.
// Path: command queue, histogram read register, response queue.
// Throughput: one beat per cycle unless the clearing pass or a full
// response side stalls it, using a read-modify-write of the histogram
// RAM with bypass of the previous write.
// Reset: registers and position return to defaults; then a clearing pass
// zeroes the 65536-entry histogram RAM, one entry per cycle, with req_full
// held high throughout. Register writes are taken meanwhile.
// A stalled response side fills the output queue, then the command queue,
// then raises req_full; nothing is dropped.
// ----------------------------------------------------------------------------
module byte_sample_unpack_histogram_core #(
   parameter int COUNT_WIDTH = bsuh_pkg::CountWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  bsuh_pkg::bsuh_req_type         req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output bsuh_pkg::bsuh_rsp_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsuh_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [bsuh_pkg::CsrDataW-1:0]  csr_data
);
   import bsuh_pkg::*;

   logic                       cmd_push, cmd_full, cmd_empty, cmd_pop;
   bsuh_cmd_type               cmd_in, cmd_head;
   logic [$clog2(CmdDepth+1)-1:0] cmd_count;
   logic                       clearing;
   logic                       out_push, out_full;
   bsuh_rsp_type               out_item;
   logic [RspCntW-1:0]         out_count;

   bsuh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .clearing  (clearing),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in)
   );

   bsuh_fifo #(
      .item_type (bsuh_cmd_type),
      .DEPTH     (CmdDepth)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   bsuh_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_item),
      .clearing  (clearing)
   );

   bsuh_fifo #(
      .item_type (bsuh_rsp_type),
      .DEPTH     (RspDepth)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .head      (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   a_cmd_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd_full |-> req_full && cmd_count == ($clog2(CmdDepth+1))'(CmdDepth))
      else $error("command queue full but requests open");

   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("response queue push while full");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full && rsp_empty)
      else $error("request taken during clearing pass");

endmodule

[dv/bsuh_checker.sv]
// ----------------------------------------------------------------------------
// bsuh_checker
// Watches the request, response and register channels of the byte sample
// unpacker, keeps its own copy of the registers, position counter and
// histogram bins, predicts every response beat and compares it field by
// field in order. Hands the failure count and the number of outstanding
// responses to the testbench top.
// ----------------------------------------------------------------------------
module bsuh_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  bsuh_pkg::bsuh_req_type        req_data,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  bsuh_pkg::bsuh_rsp_type        rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bsuh_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [bsuh_pkg::CsrDataW-1:0] csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bsuh_pkg::*;

   logic                  sgn_mode;
   logic [6:0]            chan_reg;
   logic [1:0]            pol_reg;
   logic [1:0]            dim_reg;
   int                    position;
   logic [CountWidth-1:0] bin_store [HistEntries];
   bsuh_rsp_type          expected_rsp_q [$];
   int                    failures = 0;
   int                    pending = 0;

   assign fail_count    = failures;
   assign pending_count = pending;

   initial begin
      foreach (bin_store[i]) bin_store[i] = '0;
   end

   function automatic bsuh_rsp_type unpack_beat(input bsuh_req_type beat);
      bsuh_rsp_type rsp;
      int nch, npol, ndim, ndig, pos, addr;
      nch  = (chan_reg == 0) ? 1 : (chan_reg > ChannelTop) ? ChannelTop : int'(chan_reg);
      npol = (pol_reg == 0) ? 1 : (pol_reg > 2) ? 2 : int'(pol_reg);
      ndim = (dim_reg == 0) ? 1 : (dim_reg > 2) ? 2 : int'(dim_reg);
      ndig = nch * npol * ndim;
      rsp  = '0;
      if (beat.mode == ModeReadback) begin
         rsp.is_readback = 1'b1;
         rsp.bin_count   = BinCountW'(bin_store[{beat.read_digitizer, beat.read_bin}]);
      end else begin
         pos = (position >= ndig) ? 0 : position;
         addr = pos * HistBins + int'(beat.sample_byte);
         if (bin_store[addr] != '1) bin_store[addr] += 1'b1;
         if (sgn_mode) rsp.sample_value = beat.sample_byte;
         else if (beat.sample_byte == 8'h00) rsp.sample_value = 8'sh00;
         else rsp.sample_value = beat.sample_byte ^ OffsetFlip;
         rsp.channel_index = 6'(pos / (ndim * npol));
         rsp.pol_index     = 1'((pos / ndim) % npol);
         rsp.dim_index     = 1'(pos % ndim);
         rsp.bin_count     = BinCountW'(bin_store[addr]);
         pos++;
         position = (pos >= ndig) ? 0 : pos;
      end
      return rsp;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      bsuh_rsp_type want;
      if (reset) begin
         sgn_mode = 1'b0;
         chan_reg = 7'd1;
         pol_reg  = 2'd2;
         dim_reg  = 2'd2;
         position = 0;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrSignedMode:   sgn_mode = csr_data[0];
               CsrChannelCount: chan_reg = csr_data[6:0];
               CsrPolCount:     pol_reg  = csr_data[1:0];
               CsrDimCount:     dim_reg  = csr_data[1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) expected_rsp_q.push_back(unpack_beat(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with nothing expected");
               failures++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("is_readback", want.is_readback, rsp_data.is_readback);
               check_field("sample_value", $signed(want.sample_value),
                           $signed(rsp_data.sample_value));
               check_field("channel_index", want.channel_index, rsp_data.channel_index);
               check_field("pol_index", want.pol_index, rsp_data.pol_index);
               check_field("dim_index", want.dim_index, rsp_data.dim_index);
               check_field("bin_count", want.bin_count, rsp_data.bin_count);
            end
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

[dv/tb_byte_sample_unpack_histogram_core.sv]
// ----------------------------------------------------------------------------
// tb_byte_sample_unpack_histogram_core
// Drives the byte sample unpacker: a directed pass over byte extremes,
// readbacks, clamped and stale register settings, then random phases, most
// with random register settings, byte pools that build up bin counts,
// targeted and stray readbacks, random gaps on both queues and one long
// response stall that backs the block up. Checking is done by bsuh_checker.
// ----------------------------------------------------------------------------
module tb_byte_sample_unpack_histogram_core;
   timeunit 1ns;
   timeprecision 1ps;
   import bsuh_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   bsuh_req_type        req_data;
   logic                rsp_empty;
   logic                rsp_pop;
   bsuh_rsp_type        rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_data;
   int                  fail_count;
   int                  pending_count;
   bit                  squeeze_start = 1'b0;

   byte_sample_unpack_histogram_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bsuh_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int next_gap(inout int quiet_left);
      int gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
         quiet_left = $urandom_range(16, 64);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 6);
      end
      return gap;
   endfunction

   function automatic bsuh_req_type sample_beat(input logic [7:0] value);
      bsuh_req_type beat;
      beat.mode           = ModeSample;
      beat.sample_byte    = value;
      beat.read_digitizer = 8'($urandom_range(0, 255));
      beat.read_bin       = 8'($urandom_range(0, 255));
      return beat;
   endfunction

   function automatic bsuh_req_type readback_beat(input logic [7:0] dig, input logic [7:0] bin);
      bsuh_req_type beat;
      beat.mode           = ModeReadback;
      beat.sample_byte    = 8'($urandom_range(0, 255));
      beat.read_digitizer = dig;
      beat.read_bin       = bin;
      return beat;
   endfunction

   int send_quiet = 0;

   task automatic send_beat(input bsuh_req_type beat);
      int gap;
      gap = next_gap(send_quiet);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= beat;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic drain_phase();
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // upper data bits beyond each register's width carry random noise
   task automatic program_regs(input logic sgn, input logic [6:0] ch,
                               input logic [1:0] pol, input logic [1:0] dim);
      logic [CsrIdxW-1:0]  idx_list [4];
      logic [CsrDataW-1:0] val_list [4];
      logic [CsrDataW-1:0] mask_list [4];
      idx_list  = '{CsrSignedMode, CsrChannelCount, CsrPolCount, CsrDimCount};
      val_list  = '{{7'd0, sgn}, {1'b0, ch}, {6'd0, pol}, {6'd0, dim}};
      mask_list = '{8'h01, 8'h7f, 8'h03, 8'h03};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_data  <= (8'($urandom_range(0, 255)) & ~mask_list[i]) | val_list[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : drain
      int gap;
      int quiet;
      bit squeezed;
      quiet = 0;
      squeezed = 1'b0;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = next_gap(quiet);
         if (squeeze_start && !squeezed) begin
            squeezed = 1'b1;
            gap = 400;
         end
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int         sent;
      int         phase;
      int         phase_len;
      int         nch, npol, ndim, ndig;
      logic       sgn;
      logic [6:0] ch;
      logic [1:0] pol, dim;
      logic [7:0] pool [4];
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: offset binary, four digitizers; position wraps
      send_beat(sample_beat(8'h00));
      send_beat(sample_beat(8'h80));
      send_beat(sample_beat(8'hff));
      send_beat(sample_beat(8'h7f));
      send_beat(sample_beat(8'h00));
      send_beat(sample_beat(8'h01));
      send_beat(sample_beat(8'h55));
      send_beat(readback_beat(8'd0, 8'h00));
      send_beat(readback_beat(8'd255, 8'hff));
      send_beat(readback_beat(8'd2, 8'hff));
      drain_phase();

      // zero and oversized counts clamp; position 3 is now stale
      program_regs(1'b1, 7'd0, 2'd3, 2'd0);
      send_beat(sample_beat(8'h80));
      send_beat(sample_beat(8'h7f));
      send_beat(sample_beat(8'hff));
      send_beat(sample_beat(8'h00));
      send_beat(readback_beat(8'd0, 8'h80));
      drain_phase();

      program_regs(1'b0, 7'd127, 2'd2, 2'd2);
      send_beat(sample_beat(8'h00));
      send_beat(sample_beat(8'hff));
      send_beat(sample_beat(8'h80));
      send_beat(sample_beat(8'h01));
      send_beat(sample_beat(8'h7f));
      send_beat(readback_beat(8'd3, 8'h01));
      drain_phase();

      sent = 0;
      phase = 0;
      while (sent < 1450) begin
         if (phase == 1) begin
            sgn = 1'b1;
            ch  = 7'd64;
            pol = 2'd2;
            dim = 2'd2;
         end else begin
            sgn = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
               0:       ch = 7'd0;
               1:       ch = 7'd1;
               2:       ch = 7'd64;
               3:       ch = 7'($urandom_range(65, 127));
               default: ch = 7'($urandom_range(1, 64));
            endcase
            pol = 2'($urandom_range(0, 3));
            dim = 2'($urandom_range(0, 3));
         end
         program_regs(sgn, ch, pol, dim);
         nch  = (ch == 0) ? 1 : (ch > ChannelTop) ? ChannelTop : int'(ch);
         npol = (pol == 0) ? 1 : (pol > 2) ? 2 : int'(pol);
         ndim = (dim == 0) ? 1 : (dim > 2) ? 2 : int'(dim);
         ndig = nch * npol * ndim;
         foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
         phase_len = (phase == 0) ? 200 : (phase == 1) ? 400 : $urandom_range(40, 200);
         if (phase_len > 1450 - sent) phase_len = 1450 - sent;
         if (phase == 0) squeeze_start = 1'b1;
         repeat (phase_len) begin
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 9) < 7)
                  send_beat(readback_beat(8'($urandom_range(0, ndig - 1)),
                                          pool[$urandom_range(0, 3)]));
               else
                  send_beat(readback_beat(8'($urandom_range(0, 255)),
                                          8'($urandom_range(0, 255))));
            end else if ($urandom_range(0, 3) != 0) begin
               send_beat(sample_beat(pool[$urandom_range(0, 3)]));
            end else begin
               send_beat(sample_beat(8'($urandom_range(0, 255))));
            end
            sent++;
         end
         drain_phase();
         phase++;
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/bsuh_pkg.sv
hdl/bsuh_fifo.sv
hdl/bsuh_front.sv
hdl/bsuh_back.sv
hdl/byte_sample_unpack_histogram_core.sv
dv/bsuh_checker.sv
dv/tb_byte_sample_unpack_histogram_core.sv
